// ===== sv/hlhn_pkg.sv =====
`default_nettype none

package hlhn_pkg;

  // coordinate width of the input ports
  localparam int COORD_WIDTH = 16;

  // lattice geometry
  localparam int CELL_SHIFT = 4;
  localparam int CELL_SIDE = 16;

  // corner height range
  localparam int HEIGHT_BASE = 9;
  localparam int HEIGHT_SPAN = 13;

  // hash multipliers
  localparam logic [31:0] CORNER_MUL_X = 32'h9e3779b9;
  localparam logic [31:0] CORNER_MUL_Y = 32'h85ebca6b;
  localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

  // folded residue: 2^12 is 1 mod 13, so 12-bit chunks add up to a 14-bit value
  localparam int FOLD_WIDTH = 14;
  // reciprocal of 13 for a 14-bit dividend, exact with an 18-bit shift
  localparam int RECIP_SHIFT = 18;
  localparam logic [14:0] RECIP_13 = 15'(((1 << RECIP_SHIFT) + HEIGHT_SPAN - 1) / HEIGHT_SPAN);
  localparam int QUOT_WIDTH = 10;
  localparam int PROD_WIDTH = FOLD_WIDTH + 15;

  // blend widths
  localparam int ROW_WIDTH = 9;
  localparam int SUM_WIDTH = 13;

  // cell offsets that travel along the pipeline
  typedef struct packed {
    logic [CELL_SHIFT-1:0] tx;
    logic [CELL_SHIFT-1:0] ty;
  } offset_t;

endpackage

`default_nettype wire

// ===== sv/hashed_lattice_height_noise_core.sv =====
// a word accepted with start passes the nine-stage hash and blend pipeline and
// comes out as height with done high; one word may be accepted every cycle,
// as busy stays low
// reset (rst, synchronous) clears world_seed to zero and all stage valid bits
// results are not held: done marks height for exactly one cycle
`default_nettype none

module hashed_lattice_height_noise_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [hlhn_pkg::COORD_WIDTH-1:0] x_coord,
  input  wire logic signed [hlhn_pkg::COORD_WIDTH-1:0] y_coord,
  input  wire logic                                   world_seed_we,
  input  wire logic [31:0]                            world_seed_wdata,
  output logic                                        done,
  output logic [4:0]                                  height
);

  localparam int NSTAGE = 8;

  logic [31:0] world_seed;

  // stage valid bits and the cell offsets that follow the word
  logic [NSTAGE-1:0]     vld;
  hlhn_pkg::offset_t     off [NSTAGE];

  // stage 1: lattice cell corners
  logic [31:0] gx [2];
  logic [31:0] gy [2];
  // stage 2: corner products
  logic [31:0] px [2];
  logic [31:0] py [2];
  // stage 3/4: hash finalizer halves
  logic [31:0] m3 [4];
  logic [31:0] m4 [4];
  // stage 5/6: residue fold and quotient
  logic [hlhn_pkg::FOLD_WIDTH-1:0] s5 [4];
  logic [hlhn_pkg::FOLD_WIDTH-1:0] s6 [4];
  logic [hlhn_pkg::QUOT_WIDTH-1:0] q6 [4];
  // stage 7: corner heights
  logic [4:0] ch [4];
  // stage 8: row blends
  logic [hlhn_pkg::ROW_WIDTH-1:0] row_a;
  logic [hlhn_pkg::ROW_WIDTH-1:0] row_b;

  logic                       accept;
  logic signed [31:0]         xs;
  logic signed [31:0]         ys;
  logic [31:0]                cx;
  logic [31:0]                cy;
  logic [hlhn_pkg::SUM_WIDTH-1:0] blend;

  assign busy = 1'b0;
  assign accept = start && !busy;

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      world_seed <= '0;
    end else if (world_seed_we) begin
      world_seed <= world_seed_wdata;
    end
  end

  // valid bits and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[NSTAGE-2:0], accept};
      done <= vld[NSTAGE-1];
    end
  end

  // floor split of the coordinate into cell and offset
  always_comb begin
    xs = 32'(x_coord);
    ys = 32'(y_coord);
    cx = 32'(xs >>> hlhn_pkg::CELL_SHIFT);
    cy = 32'(ys >>> hlhn_pkg::CELL_SHIFT);
  end

  always_ff @(posedge clk) begin
    gx[0] <= cx;
    gx[1] <= cx + 32'd1;
    gy[0] <= cy;
    gy[1] <= cy + 32'd1;
    off[0] <= '{tx: x_coord[hlhn_pkg::CELL_SHIFT-1:0], ty: y_coord[hlhn_pkg::CELL_SHIFT-1:0]};
    for (int i = 1; i < NSTAGE; i++) begin
      off[i] <= off[i-1];
    end
  end

  // corner coordinate products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      px[i] <= 32'(gx[i] * hlhn_pkg::CORNER_MUL_X);
      py[i] <= 32'(gy[i] * hlhn_pkg::CORNER_MUL_Y);
    end
  end

  // seed mix, first xorshift and multiply; corner k uses x+1 on bit 0, y+1 on bit 1
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic [31:0] h;
      h = px[k % 2] ^ py[k / 2] ^ world_seed;
      h = h ^ (h >> 16);
      m3[k] <= 32'(h * hlhn_pkg::HASH_MUL_A);
    end
  end

  // second xorshift and multiply
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic [31:0] h;
      h = m3[k] ^ (m3[k] >> 15);
      m4[k] <= 32'(h * hlhn_pkg::HASH_MUL_B);
    end
  end

  // last xorshift and fold of 12-bit chunks, congruent mod 13
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic [31:0] h;
      h = m4[k] ^ (m4[k] >> 16);
      s5[k] <= hlhn_pkg::FOLD_WIDTH'(h[11:0]) + hlhn_pkg::FOLD_WIDTH'(h[23:12])
             + hlhn_pkg::FOLD_WIDTH'(h[31:24]);
    end
  end

  // quotient by reciprocal multiply
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic [hlhn_pkg::PROD_WIDTH-1:0] p;
      p = hlhn_pkg::PROD_WIDTH'(s5[k]) * hlhn_pkg::PROD_WIDTH'(hlhn_pkg::RECIP_13);
      q6[k] <= hlhn_pkg::QUOT_WIDTH'(p >> hlhn_pkg::RECIP_SHIFT);
      s6[k] <= s5[k];
    end
  end

  // remainder and corner height
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic [hlhn_pkg::FOLD_WIDTH-1:0] r;
      r = s6[k] - hlhn_pkg::FOLD_WIDTH'(q6[k]) * hlhn_pkg::FOLD_WIDTH'(hlhn_pkg::HEIGHT_SPAN);
      ch[k] <= 5'(hlhn_pkg::HEIGHT_BASE) + 5'(r[3:0]);
    end
  end

  // blend along x for both rows
  always_ff @(posedge clk) begin
    logic [hlhn_pkg::ROW_WIDTH-1:0] wx0;
    logic [hlhn_pkg::ROW_WIDTH-1:0] wx1;
    wx1 = hlhn_pkg::ROW_WIDTH'(off[NSTAGE-2].tx);
    wx0 = hlhn_pkg::ROW_WIDTH'(hlhn_pkg::CELL_SIDE) - wx1;
    row_a <= hlhn_pkg::ROW_WIDTH'(ch[0]) * wx0 + hlhn_pkg::ROW_WIDTH'(ch[1]) * wx1;
    row_b <= hlhn_pkg::ROW_WIDTH'(ch[2]) * wx0 + hlhn_pkg::ROW_WIDTH'(ch[3]) * wx1;
  end

  // blend along y and divide by 256
  always_comb begin
    logic [hlhn_pkg::SUM_WIDTH-1:0] wy0;
    logic [hlhn_pkg::SUM_WIDTH-1:0] wy1;
    wy1 = hlhn_pkg::SUM_WIDTH'(off[NSTAGE-1].ty);
    wy0 = hlhn_pkg::SUM_WIDTH'(hlhn_pkg::CELL_SIDE) - wy1;
    blend = hlhn_pkg::SUM_WIDTH'(row_a) * wy0 + hlhn_pkg::SUM_WIDTH'(row_b) * wy1;
  end

  always_ff @(posedge clk) begin
    height <= 5'(blend >> (2 * hlhn_pkg::CELL_SHIFT));
  end

endmodule

`default_nettype wire
